// ===== hdl/tds_pkg.sv =====
// shared constants, codes and types of the timeout deadline scheduler
`default_nettype none

package tds_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SCAN_W     = $clog2(SLOT_COUNT + 1);

    localparam int DL_W       = 64;
    localparam int CMD_W      = 3;
    localparam int SEL_W      = 4;
    localparam int SLOT_OUT_W = 4;
    localparam int TB_W       = 2;
    localparam int COUNT_W    = 16;

    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 32;

    // scaler: values below SAT_LIMIT fit 16 bits after at most three divides by ten
    localparam int                X_W         = 26;
    localparam logic [DL_W-1:0]   SAT_LIMIT   = 64'd65536000;
    localparam logic [31:0]       DIV10_MUL   = 32'hCCCCCCCD;
    localparam int                DIV10_SHIFT = 35;
    localparam int                PROD_W      = X_W + 32;

    localparam logic [CMD_W-1:0] CMD_START    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STOP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REGISTER = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SERVICE  = 3'd4;

    localparam logic [TB_W-1:0]    TB_1US     = 2'd0;
    localparam logic [TB_W-1:0]    TB_1MS     = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_SAT  = 16'hFFFF;

    typedef struct packed {
        logic                   done;
        logic [TB_W-1:0]        timebase;
        logic [COUNT_W-1:0]     count;
    } scale_res_t;

    typedef struct packed {
        logic                   kind;
        logic                   status;
        logic [SLOT_OUT_W-1:0]  slot;
        logic                   timer_write;
        logic                   timer_enable;
        logic [TB_W-1:0]        timebase;
        logic [COUNT_W-1:0]     count;
        logic                   last;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/tds_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none

module tds_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/tds_scale.sv =====
// iterative delay scaler: picks the timebase and the 16-bit one-shot count
`default_nettype none

module tds_scale (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [tds_pkg::DL_W-1:0]    us,
    output tds_pkg::scale_res_t              res
);

    import tds_pkg::*;

    typedef enum logic [3:0] {
        SC_IDLE = 4'b0001,
        SC_LOAD = 4'b0010,
        SC_ITER = 4'b0100,
        SC_DONE = 4'b1000
    } sc_state_t;

    sc_state_t           state_reg, state_next;
    logic [DL_W-1:0]     us_reg, us_next;
    logic [X_W-1:0]      x_reg, x_next;
    logic [TB_W-1:0]     tb_reg, tb_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0]   prod;

    assign prod = PROD_W'(x_reg) * PROD_W'(DIV10_MUL);

    always_comb
    begin
        state_next = state_reg;
        us_next    = us_reg;
        x_next     = x_reg;
        tb_next    = tb_reg;
        cnt_next   = cnt_reg;
        if (start)
        begin
            us_next    = us;
            state_next = SC_LOAD;
        end
        else
        begin
            unique case (state_reg)
                SC_LOAD:
                begin
                    if (us_reg >= SAT_LIMIT)
                    begin
                        tb_next    = TB_1MS;
                        cnt_next   = COUNT_SAT;
                        state_next = SC_DONE;
                    end
                    else
                    begin
                        x_next     = us_reg[X_W-1:0];
                        tb_next    = TB_1US;
                        state_next = SC_ITER;
                    end
                end
                SC_ITER:
                begin
                    if (x_reg[X_W-1:COUNT_W] == '0)
                    begin
                        cnt_next   = x_reg[COUNT_W-1:0];
                        state_next = SC_DONE;
                    end
                    else if (tb_reg == TB_1MS)
                    begin
                        cnt_next   = COUNT_SAT;
                        state_next = SC_DONE;
                    end
                    else
                    begin
                        x_next  = X_W'(prod >> DIV10_SHIFT);
                        tb_next = tb_reg + 1'b1;
                    end
                end
                SC_IDLE, SC_DONE:
                begin
                end
                default:
                begin
                    state_next = SC_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        us_reg  <= us_next;
        x_reg   <= x_next;
        tb_reg  <= tb_next;
        cnt_reg <= cnt_next;
    end

    assign res.done     = (state_reg == SC_DONE);
    assign res.timebase = tb_reg;
    assign res.count    = cnt_reg;

    a_iter_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SC_ITER && x_reg[X_W-1:COUNT_W] != '0) |-> (tb_reg != TB_1MS))
        else $error("scaler ran past the last timebase");

    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (state_reg == SC_LOAD))
        else $error("scaler did not load on start");

    a_sat_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SC_LOAD && !start && us_reg >= SAT_LIMIT) |=>
            (res.done && res.count == COUNT_SAT && res.timebase == TB_1MS))
        else $error("large delay did not saturate");

endmodule

`default_nettype wire

// ===== hdl/timeout_deadline_scheduler_unit.sv =====
// top level of the timeout deadline scheduler: command sequencer, slot table and result register
//
// Commands arrive one per transaction and run one at a time. Start, stop, remove,
// unknown codes and failing register or service commands are answered from the
// decode state. The deadlines sit in a 16-entry ram with one read port, so every
// search for the earliest deadline sweeps the table one slot per cycle. A
// successful register takes one sweep, plus timer scaling when the new deadline
// is the earliest. Service takes one sweep per expired slot plus a final sweep
// and, if a deadline is left, the scaling. The result register lets a new
// command be accepted while the last answer still waits to be taken.
`default_nettype none

module timeout_deadline_scheduler_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tds_pkg::CMD_W-1:0]         s_tuser,  // cmd
    input  wire logic [tds_pkg::S_TDATA_W-1:0]     s_tdata,  // now_us, delay_us, slot_sel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic                                   m_tuser,  // kind
    output logic [tds_pkg::M_TDATA_W-1:0]          m_tdata,  // status, slot_out, timer_write,
                                                             // timer_enable, timebase, load_count
    output logic                                   m_tlast
);

    import tds_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DECIDE = 5'b01000,
        ST_SCALE  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [DL_W-1:0]        now_reg, now_next;
    logic [DL_W-1:0]        delay_reg, delay_next;
    logic [SEL_W-1:0]       sel_reg, sel_next;
    logic [SLOT_COUNT-1:0]  valid_reg, valid_next;
    logic                   running_reg, running_next;
    logic [SLOT_W-1:0]      new_slot_reg, new_slot_next;
    logic [SCAN_W-1:0]      scan_addr_reg, scan_addr_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [SLOT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                   best_found_reg, best_found_next;
    logic [SLOT_W-1:0]      best_idx_reg, best_idx_next;
    logic [DL_W-1:0]        best_dl_reg, best_dl_next;

    logic                   out_valid_reg;
    result_t                out_reg;

    logic                   can_load;
    logic                   emit;
    result_t                emit_item;

    logic                   ram_we;
    logic [DL_W-1:0]        ram_rdata;
    logic [DL_W:0]          dl_sum;
    logic [SLOT_W-1:0]      free_idx;
    logic                   table_full;
    logic [SLOT_W-1:0]      sel_idx;
    logic                   sel_bad;

    logic                   scale_start;
    logic [DL_W-1:0]        scale_us;
    scale_res_t             scale_res;

    tds_ram #(
        .WIDTH (DL_W),
        .DEPTH (SLOT_COUNT)
    ) u_deadline_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx),
        .wdata (dl_sum[DL_W-1:0]),
        .raddr (scan_addr_reg[SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    tds_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scale_start),
        .us    (scale_us),
        .res   (scale_res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign can_load = !out_valid_reg || m_tready;
    assign dl_sum   = {1'b0, now_reg} + {1'b0, delay_reg};
    assign table_full = &valid_reg;
    assign sel_idx  = SLOT_W'(sel_reg);
    assign sel_bad  = (int'(sel_reg) >= SLOT_COUNT) || !valid_reg[sel_idx];

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        now_next        = now_reg;
        delay_next      = delay_reg;
        sel_next        = sel_reg;
        valid_next      = valid_reg;
        running_next    = running_reg;
        new_slot_next   = new_slot_reg;
        scan_addr_next  = scan_addr_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = scan_addr_reg[SLOT_W-1:0];
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_dl_next    = best_dl_reg;
        emit            = 1'b0;
        emit_item       = '0;
        emit_item.last  = 1'b1;
        ram_we          = 1'b0;
        scale_start     = 1'b0;
        scale_us        = delay_reg;

        // earliest-deadline tracking, strict compare keeps the lowest id on ties
        if (rd_pend_reg && valid_reg[rd_idx_reg] &&
            (!best_found_reg || ram_rdata < best_dl_reg))
        begin
            best_found_next = 1'b1;
            best_idx_next   = rd_idx_reg;
            best_dl_next    = ram_rdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    now_next   = s_tdata[63:0];
                    delay_next = s_tdata[127:64];
                    sel_next   = s_tdata[131:128];
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (cmd_reg) inside
                    CMD_START, CMD_STOP:
                    begin
                        emit = 1'b1;
                        if (running_reg)
                        begin
                            emit_item.timer_write = 1'b1;
                            emit_item.timebase    = TB_1MS;
                        end
                        if (can_load)
                        begin
                            if (running_reg)
                            begin
                                valid_next = '0;
                            end
                            running_next = (cmd_reg == CMD_START);
                            state_next   = ST_IDLE;
                        end
                    end
                    CMD_REGISTER:
                    begin
                        if (!running_reg || dl_sum[DL_W] || table_full)
                        begin
                            emit             = 1'b1;
                            emit_item.status = 1'b1;
                            if (can_load)
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            ram_we               = 1'b1;
                            valid_next[free_idx] = 1'b1;
                            new_slot_next        = free_idx;
                            scan_addr_next       = '0;
                            best_found_next      = 1'b0;
                            state_next           = ST_SCAN;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        emit             = 1'b1;
                        emit_item.status = sel_bad;
                        if (can_load)
                        begin
                            if (!sel_bad)
                            begin
                                valid_next[sel_idx] = 1'b0;
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    CMD_SERVICE:
                    begin
                        if (!running_reg)
                        begin
                            emit             = 1'b1;
                            emit_item.status = 1'b1;
                            if (can_load)
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            scan_addr_next  = '0;
                            best_found_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        emit             = 1'b1;
                        emit_item.status = 1'b1;
                        if (can_load)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (scan_addr_reg < SCAN_W'(SLOT_COUNT))
                begin
                    rd_pend_next   = 1'b1;
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (cmd_reg == CMD_REGISTER)
                begin
                    if (best_idx_reg == new_slot_reg)
                    begin
                        scale_start = 1'b1;
                        scale_us    = delay_reg;
                        state_next  = ST_SCALE;
                    end
                    else
                    begin
                        emit           = 1'b1;
                        emit_item.slot = SLOT_OUT_W'(new_slot_reg);
                        if (can_load)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else if (best_found_reg && best_dl_reg <= now_reg)
                begin
                    emit           = 1'b1;
                    emit_item.kind = 1'b1;
                    emit_item.slot = SLOT_OUT_W'(best_idx_reg);
                    emit_item.last = 1'b0;
                    if (can_load)
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                        scan_addr_next           = '0;
                        best_found_next          = 1'b0;
                        state_next               = ST_SCAN;
                    end
                end
                else if (best_found_reg)
                begin
                    scale_start = 1'b1;
                    scale_us    = best_dl_reg - now_reg;
                    state_next  = ST_SCALE;
                end
                else
                begin
                    emit                  = 1'b1;
                    emit_item.timer_write = 1'b1;
                    emit_item.timebase    = TB_1MS;
                    if (can_load)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCALE:
            begin
                if (scale_res.done)
                begin
                    emit                   = 1'b1;
                    emit_item.timer_write  = 1'b1;
                    emit_item.timer_enable = 1'b1;
                    emit_item.timebase     = scale_res.timebase;
                    emit_item.count        = scale_res.count;
                    if (cmd_reg == CMD_REGISTER)
                    begin
                        emit_item.slot = SLOT_OUT_W'(new_slot_reg);
                    end
                    if (can_load)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            running_reg    <= 1'b0;
            rd_pend_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            scan_addr_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            running_reg    <= running_next;
            rd_pend_reg    <= rd_pend_next;
            best_found_reg <= best_found_next;
            scan_addr_reg  <= scan_addr_next;
            if (emit && can_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        now_reg      <= now_next;
        delay_reg    <= delay_next;
        sel_reg      <= sel_next;
        new_slot_reg <= new_slot_next;
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        best_dl_reg  <= best_dl_next;
        if (emit && can_load)
        begin
            out_reg <= emit_item;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {7'b0, out_reg.count, out_reg.timebase, out_reg.timer_enable,
                       out_reg.timer_write, out_reg.slot, out_reg.status};

    a_scan_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> running_reg)
        else $error("table sweep while stopped");

    a_new_slot_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && cmd_reg == CMD_REGISTER) |->
            (best_found_reg && valid_reg[new_slot_reg]))
        else $error("sweep after register found no entry");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_addr_reg <= SCAN_W'(SLOT_COUNT)))
        else $error("sweep address ran past the table");

    a_notice_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> !m_tlast)
        else $error("expiry notice marked as final");

endmodule

`default_nettype wire
